@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PBT_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define PBT_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`endif

@@ src/pbt_pkg.sv @@
// ----------------------------------------------------------------------------
// pbt_pkg
// Types and constants of the paged block table.
// ----------------------------------------------------------------------------
`default_nettype none
package pbt_pkg;
  localparam int NUM_SEQS = 64;
  localparam int MAX_BLOCKS_PER_SEQ = 64;
  localparam int SEQ_W = 6;
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;
  localparam int ADDR_W = SEQ_W + IDX_W;
  localparam int DEPTH = NUM_SEQS * MAX_BLOCKS_PER_SEQ;
  localparam logic [31:0] INVALID_ID = 32'hFFFF_FFFF;
  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0, CMD_SWAP = 3'd1, CMD_LOOKUP = 3'd2, CMD_LOOKPOS = 3'd3,
    CMD_COUNT = 3'd4, CMD_CLEAR = 3'd5, CMD_CLEARALL = 3'd6, CMD_NONE = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_SEQ = 3'd1, ST_INDEX = 3'd2, ST_FULL = 3'd3,
    ST_EMPTY = 3'd4, ST_POS = 3'd5
  } status_t;

  localparam logic CFG_BLOCK_SIZE = 1'b0;
  localparam logic CFG_ACTIVE_SEQS = 1'b1;

  // Classified item handed from the front to the back.
  typedef struct packed {
    cmd_t            cmd;
    logic [SEQ_W-1:0] seq;
    logic [IDX_W-1:0] idx;
    logic [31:0]     pos;
    logic [31:0]     nid;
    logic            seq_ok;
    logic            pos_bad;
  } item_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_READ, S_WAIT, S_EMIT, S_CLR
  } bstate_t;
endpackage
`default_nettype wire

@@ src/pbt_ram.sv @@
// ----------------------------------------------------------------------------
// pbt_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module pbt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ src/pbt_front.sv @@
// ----------------------------------------------------------------------------
// pbt_front
// Accepts commands, checks the sequence range, the position sign and a zero block
// size, and queues classified items for the back end; CMD_NONE is not queued.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module pbt_front import pbt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [SEQ_W-1:0] in_seq,
  input  wire logic [IDX_W-1:0] in_idx,
  input  wire logic [31:0] in_pos,
  input  wire logic [31:0] in_nid,
  input  wire logic [15:0] bsize,
  input  wire logic [6:0]  active_seqs,
  output      logic        q_valid,
  input  wire logic        q_pop,
  output      item_t       q_item
);
  item_t     q_r [QDEPTH];
  logic      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic      push;
  item_t     it;

  assign in_ready = (cnt_r != 2'(QDEPTH));
  assign push = in_valid && in_ready && (in_cmd != CMD_NONE);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = q_r[rp_r];

  // Classify the incoming command.
  always_comb begin
    it.cmd = cmd_t'(in_cmd);
    it.seq = in_seq;
    it.idx = in_idx;
    it.pos = in_pos;
    it.nid = in_nid;
    it.seq_ok = ({1'b0, in_seq} < active_seqs);
    it.pos_bad = in_pos[31] || (bsize == 16'd0);
  end

  always_comb begin
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = (q_pop && q_valid) ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop && q_valid);
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= it;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `PBT_ASSERT_IMP(a_cnt_max, clk, rst_n, 1'b1, cnt_r <= 2'(QDEPTH), "queue overflow")
  `PBT_ASSERT_NXT(a_push_cnt, clk, rst_n, push && !q_pop, cnt_r == $past(cnt_r) + 2'd1,
    "queue count not advanced")
endmodule
`default_nettype wire

@@ src/pbt_back.sv @@
// ----------------------------------------------------------------------------
// pbt_back
// Executes queued commands against the row lengths and the entry RAM and
// drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module pbt_back import pbt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output      logic        q_pop,
  input  wire item_t       q_item,
  input  wire logic [15:0] bsize,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [31:0] out_id,
  output      logic [6:0]  out_count,
  output      logic [2:0]  out_status,
  output      logic        out_last
);
  bstate_t st_r, st_nxt;
  // A row length is valid only once written since reset or the last clear all.
  logic [NUM_SEQS-1:0] lval_r;
  logic [SEQ_W-1:0] len_raddr;
  logic [CNT_W-1:0] len_rdata;
  logic ov_r, ov_nxt;
  logic [31:0] oid_r, oid_nxt;
  logic [6:0] ocnt_r, ocnt_nxt;
  logic [2:0] ost_r, ost_nxt;
  logic olast_r, olast_nxt;
  item_t cur_r, cur_nxt;
  // Divider: restoring, one quotient bit a cycle.
  logic [31:0] quo_r, quo_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [5:0] dc_r, dc_nxt;
  logic [16:0] trial;
  logic [CNT_W-1:0] ci_r, ci_nxt;
  logic swap_r, swap_nxt;
  logic we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;
  logic [CNT_W-1:0] clen;
  logic len_we, len_clr_all;
  logic [CNT_W-1:0] len_wval;
  logic out_free;

  pbt_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Row lengths; the sequence being popped is read so its length is ready next cycle.
  pbt_ram #(.WIDTH(CNT_W), .DEPTH(NUM_SEQS)) u_len (
    .clk(clk), .we(len_we), .waddr(cur_r.seq), .wdata(len_wval), .raddr(len_raddr),
    .rdata(len_rdata)
  );

  assign out_valid = ov_r;
  assign out_id = oid_r;
  assign out_count = ocnt_r;
  assign out_status = ost_r;
  assign out_last = olast_r;
  assign out_free = !ov_r || out_ready;
  assign len_raddr = (st_r == S_IDLE) ? q_item.seq : cur_r.seq;
  assign clen = lval_r[cur_r.seq] ? len_rdata : '0;
  assign trial = {rem_r, quo_r[31]} - {1'b0, bsize};

  // Sequencer for one command at a time.
  always_comb begin
    st_nxt = st_r;
    cur_nxt = cur_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dc_nxt = dc_r;
    ci_nxt = ci_r;
    swap_nxt = swap_r;
    ov_nxt = ov_r && !out_ready;
    oid_nxt = oid_r;
    ocnt_nxt = ocnt_r;
    ost_nxt = ost_r;
    olast_nxt = olast_r;
    q_pop = 1'b0;
    we = 1'b0;
    waddr = {cur_r.seq, cur_r.idx};
    wdata = cur_r.nid;
    raddr = {cur_r.seq, cur_r.idx};
    len_we = 1'b0;
    len_clr_all = 1'b0;
    len_wval = '0;
    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          cur_nxt = q_item;
          quo_nxt = q_item.pos;
          rem_nxt = '0;
          dc_nxt = '0;
          st_nxt = (q_item.cmd == CMD_LOOKPOS && !q_item.pos_bad) ? S_DIV : S_READ;
        end
      end
      S_DIV: begin
        if (trial[16]) begin
          rem_nxt = {rem_r[14:0], quo_r[31]};
          quo_nxt = {quo_r[30:0], 1'b0};
        end else begin
          rem_nxt = trial[15:0];
          quo_nxt = {quo_r[30:0], 1'b1};
        end
        dc_nxt = dc_r + 6'd1;
        if (dc_r == 6'd31) begin
          st_nxt = S_READ;
        end
      end
      S_READ: begin
        // Decide the outcome; only a non-empty clear gives more than one output.
        if (out_free) begin
          ov_nxt = 1'b1;
          oid_nxt = INVALID_ID;
          ocnt_nxt = '0;
          olast_nxt = 1'b1;
          st_nxt = S_IDLE;
          case (cur_r.cmd)
            CMD_APPEND: begin
              if (!cur_r.seq_ok) ost_nxt = ST_SEQ;
              else if (clen >= CNT_W'(MAX_BLOCKS_PER_SEQ)) ost_nxt = ST_FULL;
              else begin
                we = 1'b1;
                waddr = {cur_r.seq, clen[IDX_W-1:0]};
                len_we = 1'b1;
                len_wval = clen + CNT_W'(1);
                oid_nxt = '0;
                ost_nxt = ST_OK;
              end
            end
            CMD_SWAP, CMD_LOOKUP: begin
              if (!cur_r.seq_ok) ost_nxt = ST_SEQ;
              else if ({1'b0, cur_r.idx} >= clen) ost_nxt = ST_INDEX;
              else begin
                ov_nxt = ov_r && !out_ready;
                swap_nxt = (cur_r.cmd == CMD_SWAP);
                st_nxt = S_WAIT;
              end
            end
            CMD_LOOKPOS: begin
              if (cur_r.pos_bad) ost_nxt = ST_POS;
              else if (!cur_r.seq_ok) ost_nxt = ST_SEQ;
              else if (quo_r >= {25'd0, clen}) ost_nxt = ST_INDEX;
              else begin
                ov_nxt = ov_r && !out_ready;
                cur_nxt.idx = quo_r[IDX_W-1:0];
                swap_nxt = 1'b0;
                st_nxt = S_WAIT;
              end
            end
            CMD_COUNT: begin
              if (!cur_r.seq_ok) ost_nxt = ST_SEQ;
              else begin
                oid_nxt = '0;
                ocnt_nxt = clen;
                ost_nxt = ST_OK;
              end
            end
            CMD_CLEAR: begin
              if (!cur_r.seq_ok) ost_nxt = ST_SEQ;
              else if (clen == '0) ost_nxt = ST_EMPTY;
              else begin
                ov_nxt = ov_r && !out_ready;
                ci_nxt = '0;
                st_nxt = S_CLR;
              end
            end
            CMD_CLEARALL: begin
              len_clr_all = 1'b1;
              oid_nxt = '0;
              ost_nxt = ST_OK;
            end
            default: begin
              ov_nxt = ov_r && !out_ready;
            end
          endcase
        end
      end
      S_WAIT: begin
        // Read address presented; data arrives next cycle.
        st_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          oid_nxt = rdata;
          ocnt_nxt = '0;
          ost_nxt = ST_OK;
          olast_nxt = (cur_r.cmd != CMD_CLEAR) || (ci_r + CNT_W'(1) == clen);
          if (cur_r.cmd == CMD_CLEAR) begin
            if (ci_r + CNT_W'(1) == clen) begin
              len_we = 1'b1;
              len_wval = '0;
              st_nxt = S_IDLE;
            end else begin
              ci_nxt = ci_r + CNT_W'(1);
              st_nxt = S_CLR;
            end
          end else begin
            we = swap_r;
            st_nxt = S_IDLE;
          end
        end
      end
      S_CLR: begin
        raddr = {cur_r.seq, ci_r[IDX_W-1:0]};
        st_nxt = S_EMIT;
      end
      default: st_nxt = S_IDLE;
    endcase
    if (st_r == S_WAIT || st_r == S_EMIT) begin
      raddr = {cur_r.seq, cur_r.idx};
    end
    if ((st_r == S_EMIT) && (cur_r.cmd == CMD_CLEAR)) begin
      raddr = {cur_r.seq, ci_r[IDX_W-1:0]};
    end
  end

  // Row length valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lval_r <= '0;
    end else if (len_clr_all) begin
      lval_r <= '0;
    end else if (len_we) begin
      lval_r[cur_r.seq] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dc_r <= dc_nxt;
    ci_r <= ci_nxt;
    swap_r <= swap_nxt;
    oid_r <= oid_nxt;
    ocnt_r <= ocnt_nxt;
    ost_r <= ost_nxt;
    olast_r <= olast_nxt;
  end

  `PBT_ASSERT_NXT(a_hold, clk, rst_n, ov_r && !out_ready, ov_r && $stable(oid_r),
    "result changed while stalled")
  `PBT_ASSERT_IMP(a_pop_idle, clk, rst_n, q_pop, st_r == S_IDLE, "pop while busy")
  `PBT_ASSERT_IMP(a_we_one, clk, rst_n, len_we, !len_clr_all, "two length writes")
endmodule
`default_nettype wire

@@ src/paged_block_table_top.sv @@
// ----------------------------------------------------------------------------
// paged_block_table_top
// Per-sequence logical-to-physical block table with a command front end and
// an execution back end.
// ----------------------------------------------------------------------------
// Channel  | Direction | Contents
// in_      | slave     | tdata: command, seq, logical_index, position, new_block_id
// out_     | master    | tdata: block_id, row_count, status; tlast: last
// cfg_     | write     | 0 tokens per block, 1 active sequences
// A command passes through S_IDLE and S_READ in the back end before its result is
// registered; a swap or any lookup that hits also goes through S_WAIT and S_EMIT for the
// registered entry read. A position lookup with a valid position first runs the bit-serial
// divider in S_DIV; a row clear steps through S_CLR and S_EMIT per freed id; a stall on
// out_ holds the back end. Reset clears the queue, the sequencer and the row-length valid
// bits at once. The two-entry queue lets the front accept while the back end stalls on out_.
`default_nettype none
module paged_block_table_top import pbt_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  // [2:0] command, [8:3] seq, [14:9] logical_index, [46:15] position,
  // [78:47] new_block_id, [79] zero
  input  wire logic [79:0]  in_tdata,
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  // [31:0] block_id, [38:32] row_count, [41:39] status, [47:42] zero
  output      logic [47:0]  out_tdata,
  output      logic         out_tlast,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [15:0]  cfg_data
);
  logic [15:0] bsize_r;
  logic [6:0] aseq_r;
  logic q_valid, q_pop;
  item_t q_item;
  logic [31:0] oid;
  logic [6:0] ocnt;
  logic [2:0] ost;

  // Configuration registers; active_seqs is not capped at the table size.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsize_r <= 16'd16;
      aseq_r <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BLOCK_SIZE) bsize_r <= cfg_data;
      else aseq_r <= cfg_data[6:0];
    end
  end

  pbt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_cmd(in_tdata[2:0]), .in_seq(in_tdata[8:3]), .in_idx(in_tdata[14:9]),
    .in_pos(in_tdata[46:15]), .in_nid(in_tdata[78:47]),
    .bsize(bsize_r), .active_seqs(aseq_r),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  pbt_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .bsize(bsize_r), .out_valid(out_tvalid), .out_ready(out_tready),
    .out_id(oid), .out_count(ocnt), .out_status(ost), .out_last(out_tlast)
  );

  assign out_tdata = {6'd0, ost, ocnt, oid};
endmodule
`default_nettype wire

@@ test/tb_paged_block_table_top.sv @@
// ----------------------------------------------------------------------------
// tb_paged_block_table_top
// Drives commands into the block table and checks every result transfer.
// A short directed table comes first. Its rows carry a fixed expectation
// where the answer is obvious; every other row goes through the predictor.
// Random phases follow. Each one rewrites both registers and changes how
// often the sender idles and the receiver stalls. One phase fills a row to
// capacity so that the row-full case and a long clear are reached.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_paged_block_table_top;
  import pbt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [31:0] block_id;
    logic [6:0]  row_count;
    status_t     status;
    logic        last;
  } result_t;

  typedef struct {
    cmd_t        cmd;
    logic [5:0]  seq;
    logic [5:0]  idx;
    logic [31:0] pos;
    logic [31:0] nid;
    bit          fixed;
    logic [31:0] fixed_id;
    logic [6:0]  fixed_cnt;
    status_t     fixed_st;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  // Mirror of the table state and registers.
  logic [31:0] tbl_ids [NUM_SEQS][MAX_BLOCKS_PER_SEQ];
  int          tbl_len [NUM_SEQS];
  logic [15:0] blk_size = 16'd16;
  logic [6:0]  seqs_active = 7'd64;

  result_t     pending_results [$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;

  paged_block_table_top dut (.*);

  always #6 clk = ~clk;

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: id %h cnt %0d st %0d last %b",
                   out_tdata[31:0], out_tdata[38:32], out_tdata[41:39], out_tlast);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[31:0] !== want.block_id || out_tdata[38:32] !== want.row_count ||
            out_tdata[41:39] !== want.status || out_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected id %h cnt %0d st %0d last %b, ",
                      "got id %h cnt %0d st %0d last %b"},
                     want.block_id, want.row_count, want.status, want.last,
                     out_tdata[31:0], out_tdata[38:32], out_tdata[41:39], out_tlast);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_paged_block_table_top failed");
      $finish;
    end
  end

  function automatic bit seq_in_range(logic [5:0] s);
    int lim;
    lim = (seqs_active < NUM_SEQS) ? seqs_active : NUM_SEQS;
    return s < lim;
  endfunction

  function automatic void push_result(logic [31:0] id, logic [6:0] cnt, status_t st,
                                      logic lst);
    result_t r;
    r.block_id = id;
    r.row_count = cnt;
    r.status = st;
    r.last = lst;
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Work out the results of one accepted command and update the mirror.
  function automatic void table_predict(cmd_t cmd, logic [5:0] s, logic [5:0] idx,
                                        logic [31:0] pos, logic [31:0] nid);
    logic [31:0] quot;
    int n;
    case (cmd)
      CMD_APPEND: begin
        if (!seq_in_range(s)) push_result(INVALID_ID, 7'd0, ST_SEQ, 1'b1);
        else if (tbl_len[s] >= MAX_BLOCKS_PER_SEQ)
          push_result(INVALID_ID, 7'd0, ST_FULL, 1'b1);
        else begin
          tbl_ids[s][tbl_len[s]] = nid;
          tbl_len[s]++;
          push_result(32'd0, 7'd0, ST_OK, 1'b1);
        end
      end
      CMD_SWAP: begin
        if (!seq_in_range(s)) push_result(INVALID_ID, 7'd0, ST_SEQ, 1'b1);
        else if (idx >= tbl_len[s]) push_result(INVALID_ID, 7'd0, ST_INDEX, 1'b1);
        else begin
          push_result(tbl_ids[s][idx], 7'd0, ST_OK, 1'b1);
          tbl_ids[s][idx] = nid;
        end
      end
      CMD_LOOKUP, CMD_LOOKPOS: begin
        quot = 32'(idx);
        if (cmd == CMD_LOOKPOS && (pos[31] || blk_size == 0))
          push_result(INVALID_ID, 7'd0, ST_POS, 1'b1);
        else begin
          if (cmd == CMD_LOOKPOS) quot = pos / {16'd0, blk_size};
          if (!seq_in_range(s)) push_result(INVALID_ID, 7'd0, ST_SEQ, 1'b1);
          else if (quot >= tbl_len[s]) push_result(INVALID_ID, 7'd0, ST_INDEX, 1'b1);
          else push_result(tbl_ids[s][quot], 7'd0, ST_OK, 1'b1);
        end
      end
      CMD_COUNT: begin
        if (!seq_in_range(s)) push_result(INVALID_ID, 7'd0, ST_SEQ, 1'b1);
        else push_result(32'd0, 7'(tbl_len[s]), ST_OK, 1'b1);
      end
      CMD_CLEAR: begin
        n = tbl_len[s];
        if (!seq_in_range(s)) push_result(INVALID_ID, 7'd0, ST_SEQ, 1'b1);
        else if (n == 0) push_result(INVALID_ID, 7'd0, ST_EMPTY, 1'b1);
        else begin
          for (int i = 0; i < n; i++)
            push_result(tbl_ids[s][i], 7'd0, ST_OK, i == n - 1);
          tbl_len[s] = 0;
        end
      end
      CMD_CLEARALL: begin
        foreach (tbl_len[i]) tbl_len[i] = 0;
        push_result(32'd0, 7'd0, ST_OK, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // Offer one command and hold it until the transfer, then maybe idle.
  task automatic send_cmd(cmd_t cmd, logic [5:0] s, logic [5:0] idx, logic [31:0] pos,
                          logic [31:0] nid);
    in_tdata <= {1'b0, nid, pos, idx, s, cmd};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    table_predict(cmd, s, idx, pos, nid);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  // Registers change only once the block has gone quiet.
  task automatic write_regs(logic [15:0] bs, logic [6:0] act);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_BLOCK_SIZE;
    cfg_data <= bs;
    @(posedge clk);
    cfg_index <= CFG_ACTIVE_SEQS;
    cfg_data <= {9'd0, act};
    @(posedge clk);
    cfg_we <= 1'b0;
    blk_size = bs;
    seqs_active = act;
  endtask

  // Mostly well-formed commands aimed at a few busy rows, some noise.
  task automatic send_random();
    int r, lim, len;
    logic [5:0] s, idx;
    logic [31:0] pos;
    cmd_t cmd;
    r = $urandom_range(99);
    lim = (seqs_active < NUM_SEQS) ? seqs_active : NUM_SEQS;
    s = ($urandom_range(9) == 0 || lim == 0) ? 6'($urandom) :
        6'($urandom_range(0, (lim < 4) ? lim - 1 : 3));
    len = tbl_len[s];
    idx = (len > 0 && $urandom_range(7) != 0) ? 6'($urandom_range(0, len - 1)) :
          6'($urandom);
    pos = $urandom;
    if (blk_size != 0 && $urandom_range(7) != 0)
      pos = idx * blk_size + $urandom_range(0, blk_size - 1);
    if (r < 40) cmd = CMD_APPEND;
    else if (r < 55) cmd = CMD_LOOKUP;
    else if (r < 65) cmd = CMD_LOOKPOS;
    else if (r < 73) cmd = CMD_SWAP;
    else if (r < 80) cmd = CMD_COUNT;
    else if (r < 88) cmd = CMD_CLEAR;
    else if (r < 90) cmd = CMD_CLEARALL;
    else begin
      cmd = cmd_t'($urandom_range(0, 7));
      s = 6'($urandom);
      idx = 6'($urandom);
      pos = $urandom;
    end
    send_cmd(cmd, s, idx, pos, $urandom);
  endtask

  dir_row_t dir_rows [] = '{
    '{CMD_COUNT,    6'd0,  6'd0,  32'd0,         32'd0,         1, 32'd0,      7'd0, ST_OK},
    '{CMD_LOOKUP,   6'd0,  6'd0,  32'd0,         32'd0,         1, INVALID_ID, 7'd0, ST_INDEX},
    '{CMD_CLEAR,    6'd63, 6'd0,  32'd0,         32'd0,         1, INVALID_ID, 7'd0, ST_EMPTY},
    '{CMD_LOOKPOS,  6'd0,  6'd0,  32'h8000_0000, 32'd0,         1, INVALID_ID, 7'd0, ST_POS},
    '{CMD_APPEND,   6'd0,  6'd0,  32'd0,         32'd0,         1, 32'd0,      7'd0, ST_OK},
    '{CMD_APPEND,   6'd0,  6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd0,      7'd0, ST_OK},
    '{CMD_APPEND,   6'd63, 6'd0,  32'd0,         32'h1234_5678, 1, 32'd0,      7'd0, ST_OK},
    '{CMD_LOOKUP,   6'd0,  6'd1,  32'd0,         32'd0,         0, 32'd0,      7'd0, ST_OK},
    '{CMD_SWAP,     6'd0,  6'd0,  32'd0,         32'hA5A5_A5A5, 0, 32'd0,      7'd0, ST_OK},
    '{CMD_SWAP,     6'd0,  6'd63, 32'd0,         32'h5A5A_5A5A, 1, INVALID_ID, 7'd0, ST_INDEX},
    '{CMD_LOOKPOS,  6'd0,  6'd0,  32'd16,        32'd0,         0, 32'd0,      7'd0, ST_OK},
    '{CMD_LOOKPOS,  6'd0,  6'd0,  32'h7FFF_FFFF, 32'd0,         1, INVALID_ID, 7'd0, ST_INDEX},
    '{CMD_LOOKPOS,  6'd0,  6'd0,  32'd15,        32'd0,         0, 32'd0,      7'd0, ST_OK},
    '{CMD_COUNT,    6'd0,  6'd0,  32'd0,         32'd0,         0, 32'd0,      7'd0, ST_OK},
    '{CMD_NONE,     6'd0,  6'd0,  32'd0,         32'd0,         0, 32'd0,      7'd0, ST_OK},
    '{CMD_CLEAR,    6'd0,  6'd0,  32'd0,         32'd0,         0, 32'd0,      7'd0, ST_OK},
    '{CMD_COUNT,    6'd0,  6'd0,  32'd0,         32'd0,         1, 32'd0,      7'd0, ST_OK},
    '{CMD_APPEND,   6'd5,  6'd0,  32'd0,         32'hDEAD_BEEF, 1, 32'd0,      7'd0, ST_OK},
    '{CMD_APPEND,   6'd5,  6'd0,  32'd0,         32'h0BAD_F00D, 1, 32'd0,      7'd0, ST_OK},
    '{CMD_CLEARALL, 6'd0,  6'd0,  32'd0,         32'd0,         1, 32'd0,      7'd0, ST_OK},
    '{CMD_COUNT,    6'd5,  6'd0,  32'd0,         32'd0,         1, 32'd0,      7'd0, ST_OK},
    '{CMD_CLEAR,    6'd5,  6'd0,  32'd0,         32'd0,         1, INVALID_ID, 7'd0, ST_EMPTY},
    '{CMD_LOOKUP,   6'd63, 6'd63, 32'd0,         32'd0,         1, INVALID_ID, 7'd0, ST_INDEX}
  };

  logic [15:0] phase_bs  [8] = '{16'd16, 16'd1, 16'd65535, 16'd0, 16'd3, 16'd7, 16'd16, 16'd2};
  logic [6:0]  phase_act [8] = '{7'd64, 7'd1, 7'd64, 7'd0, 7'd5, 7'd64, 7'd2, 7'd64};

  initial begin
    foreach (tbl_len[i]) tbl_len[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; fixed rows replace the predicted single result.
    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].cmd, dir_rows[i].seq, dir_rows[i].idx, dir_rows[i].pos,
               dir_rows[i].nid);
      if (dir_rows[i].fixed) begin
        void'(pending_results.pop_back());
        push_result(dir_rows[i].fixed_id, dir_rows[i].fixed_cnt, dir_rows[i].fixed_st, 1'b1);
      end
    end

    // Random phases with changing registers and handshake pressure.
    for (int p = 0; p < 8; p++) begin
      write_regs(phase_bs[p] == 16'd7 ? 16'($urandom_range(2, 40)) : phase_bs[p],
                 phase_act[p]);
      sender_idle_pct = (p % 4 == 1) ? 84 : (p % 4 == 3) ? 7 : 0;
      recv_stall_pct  = (p % 4 == 2) ? 84 : (p % 4 == 3) ? 7 : 0;
      if (p == 6) begin
        // Fill one row past capacity, then free it in one long clear.
        send_cmd(CMD_CLEAR, 6'd1, 6'd0, 32'd0, 32'd0);
        for (int k = 0; k < MAX_BLOCKS_PER_SEQ + 2; k++)
          send_cmd(CMD_APPEND, 6'd1, 6'd0, 32'd0, $urandom);
        send_cmd(CMD_LOOKPOS, 6'd1, 6'd0, 32'd127, 32'd0);
        send_cmd(CMD_CLEAR, 6'd1, 6'd0, 32'd0, 32'd0);
      end else begin
        repeat (48) send_random();
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("tb_paged_block_table_top passed");
    else
      $display("tb_paged_block_table_top failed");
    $finish;
  end
endmodule
`default_nettype wire
